// ===== hw/rtl/lxc_pkg.sv =====
`default_nettype none
package lxc_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned CNT_W   = $clog2(DIV_STEPS);
  localparam int unsigned STEP_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // keystream bits that cover the data byte
  localparam int unsigned KS_LSB = 20;

  localparam logic [WORD_W-1:0] DEF_SEED       = 32'd1;
  localparam logic [WORD_W-1:0] DEF_MODULUS    = 32'd1 << 19;
  localparam logic [WORD_W-1:0] DEF_MULTIPLIER = 32'd2 << 20;
  localparam logic [WORD_W-1:0] DEF_INCREMENT  = 32'd3 << 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED       = 2'd0,
    REG_MODULUS    = 2'd1,
    REG_MULTIPLIER = 2'd2,
    REG_INCREMENT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_NO_INPUT = 2'd1,
    COND_DIV_MORE = 2'd2,
    COND_OUT_BUSY = 2'd3
  } cond_t;

  typedef enum logic [STEP_W-1:0] {
    STEP_LOAD = 2'd0,
    STEP_DIV  = 2'd1,
    STEP_MUL  = 2'd2,
    STEP_ADD  = 2'd3
  } step_t;

  // one control word of the microprogram
  typedef struct packed {
    logic       take_in;
    logic       div_step;
    logic       mul_step;
    logic       add_step;
    cond_t      cond;
    step_t      target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_acc;
    logic div_more;
    logic out_busy;
    logic out_load;
  } status_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w = '0;
    unique case (step)
      STEP_LOAD: begin
        w.take_in = 1'b1;
        w.cond    = COND_NO_INPUT;
        w.target  = STEP_LOAD;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_MORE;
        w.target   = STEP_DIV;
      end
      STEP_MUL: begin
        w.mul_step = 1'b1;
        w.cond     = COND_NONE;
        w.target   = STEP_MUL;
      end
      STEP_ADD: begin
        w.add_step = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.target   = STEP_ADD;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lxc_seq.sv =====
`default_nettype none
module lxc_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lxc_pkg::status_t stat,
  output lxc_pkg::uword_t       ctrl
);

  lxc_pkg::step_t step;
  lxc_pkg::step_t step_next;
  logic           jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lxc_pkg::STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = lxc_pkg::ucode_rom(step);
    unique case (ctrl.cond)
      lxc_pkg::COND_NONE:     jump = 1'b0;
      lxc_pkg::COND_NO_INPUT: jump = !stat.in_acc;
      lxc_pkg::COND_DIV_MORE: jump = stat.div_more;
      lxc_pkg::COND_OUT_BUSY: jump = stat.out_busy;
      default:                jump = 1'b0;
    endcase
    // fall through wraps from the last step back to the load step
    step_next = jump ? ctrl.target : lxc_pkg::step_t'(step + 1'b1);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lxc_dp.sv =====
`default_nettype none
module lxc_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lxc_pkg::uword_t              ctrl,
  input  wire logic                         in_valid,
  input  wire logic [lxc_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                         in_first,
  input  wire logic [lxc_pkg::WORD_W-1:0]   seed,
  input  wire logic [lxc_pkg::WORD_W-1:0]   modulus,
  input  wire logic [lxc_pkg::WORD_W-1:0]   multiplier,
  input  wire logic [lxc_pkg::WORD_W-1:0]   increment,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [lxc_pkg::BYTE_W-1:0]        out_byte,
  output lxc_pkg::status_t                  stat
);

  logic [lxc_pkg::WORD_W-1:0] state;
  logic [lxc_pkg::WORD_W-1:0] quo;
  logic [lxc_pkg::WORD_W-1:0] rem;
  logic [lxc_pkg::CNT_W-1:0]  cnt;
  logic [lxc_pkg::BYTE_W-1:0] data;
  logic [lxc_pkg::WORD_W-1:0] prod;
  logic [lxc_pkg::WORD_W:0]   trial;
  logic [lxc_pkg::WORD_W:0]   diff;
  logic [lxc_pkg::WORD_W-1:0] state_next;

  always_comb begin
    trial      = {rem, quo[lxc_pkg::WORD_W-1]};
    diff       = trial - {1'b0, modulus};
    state_next = prod + increment;

    stat.in_acc   = in_valid && ctrl.take_in;
    stat.div_more = (cnt != '0);
    stat.out_busy = out_valid && !out_ready;
    stat.out_load = ctrl.add_step && !stat.out_busy;
  end

  // input load, restoring divider (one remainder bit per step), multiply and output byte
  always_ff @(posedge clk) begin
    if (stat.in_acc) begin
      quo  <= in_first ? seed : state;
      rem  <= '0;
      cnt  <= '1;
      data <= in_byte;
    end else if (ctrl.div_step) begin
      quo <= {quo[lxc_pkg::WORD_W-2:0], 1'b0};
      rem <= diff[lxc_pkg::WORD_W] ? trial[lxc_pkg::WORD_W-1:0]
                                   : diff[lxc_pkg::WORD_W-1:0];
      cnt <= cnt - 1'b1;
    end
    if (ctrl.mul_step) begin
      prod <= multiplier * rem;
    end
    if (stat.out_load) begin
      out_byte <= data ^ state_next[lxc_pkg::KS_LSB +: lxc_pkg::BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lxc_pkg::DEF_SEED;
      out_valid <= 1'b0;
    end else begin
      if (stat.out_load) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lcg_xor_stream_cipher.sv =====
// channel    dir  handshake                      payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: data_byte, tuser: first
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: out_byte
// cfg        in   cfg_we                         cfg_index, cfg_data
//
// one word is in work at a time; it passes a load step, 32 steps of the
// restoring divider for the modulus, a multiply step and an add step.
// the next word is taken while the result still waits in the output register.
// a stalled output holds the add step until the output register frees.
// rst is synchronous: config registers take their defaults, keystream word is 1.
`default_nettype none
module lcg_xor_stream_cipher (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  wire logic                            s_axis_tuser,  // [0] first
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // [7:0] out_byte
  input  wire logic                            cfg_we,
  input  wire logic [lxc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lxc_pkg::WORD_W-1:0]      cfg_data
);

  logic [lxc_pkg::WORD_W-1:0] seed;
  logic [lxc_pkg::WORD_W-1:0] modulus;
  logic [lxc_pkg::WORD_W-1:0] multiplier;
  logic [lxc_pkg::WORD_W-1:0] increment;
  logic [lxc_pkg::WORD_W-1:0] seed_eff;
  logic [lxc_pkg::WORD_W-1:0] modulus_eff;
  logic [lxc_pkg::WORD_W-1:0] multiplier_eff;
  logic [lxc_pkg::WORD_W-1:0] increment_eff;
  lxc_pkg::uword_t            ctrl;
  lxc_pkg::status_t           stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= lxc_pkg::DEF_SEED;
      modulus    <= lxc_pkg::DEF_MODULUS;
      multiplier <= lxc_pkg::DEF_MULTIPLIER;
      increment  <= lxc_pkg::DEF_INCREMENT;
    end else if (cfg_we) begin
      unique case (lxc_pkg::cfg_reg_t'(cfg_index))
        lxc_pkg::REG_SEED:       seed       <= cfg_data;
        lxc_pkg::REG_MODULUS:    modulus    <= cfg_data;
        lxc_pkg::REG_MULTIPLIER: multiplier <= cfg_data;
        lxc_pkg::REG_INCREMENT:  increment  <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero in a register selects its default
  always_comb begin
    seed_eff       = (seed == '0)       ? lxc_pkg::DEF_SEED       : seed;
    modulus_eff    = (modulus == '0)    ? lxc_pkg::DEF_MODULUS    : modulus;
    multiplier_eff = (multiplier == '0) ? lxc_pkg::DEF_MULTIPLIER : multiplier;
    increment_eff  = (increment == '0)  ? lxc_pkg::DEF_INCREMENT  : increment;
  end

  assign s_axis_tready = ctrl.take_in;

  lxc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  lxc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_valid   (s_axis_tvalid),
    .in_byte    (s_axis_tdata),
    .in_first   (s_axis_tuser),
    .seed       (seed_eff),
    .modulus    (modulus_eff),
    .multiplier (multiplier_eff),
    .increment  (increment_eff),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_byte   (m_axis_tdata),
    .stat       (stat)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    stat.out_load |=> m_axis_tvalid)
    else $error("computed result not presented");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !stat.out_load |=> !m_axis_tvalid)
    else $error("result repeated after it was taken");

  a_no_load_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten while stalled");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } cipher_in_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;   // [7:0] data_byte
  logic                          s_axis_tuser = 1'b0; // [0] first
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;        // [7:0] out_byte
  logic                          cfg_we = 1'b0;
  logic [lxc_pkg::CFG_IDX_W-1:0] cfg_index = lxc_pkg::REG_SEED;
  logic [lxc_pkg::WORD_W-1:0]    cfg_data = '0;

  // register copies and keystream word kept by the predictor
  logic [lxc_pkg::WORD_W-1:0] cfg_shadow [4];
  logic [lxc_pkg::WORD_W-1:0] ks_word;

  cipher_in_t  tx_words [$];
  cipher_in_t  tx_next;
  logic [7:0]  out_expect_q [$];
  logic [7:0]  out_want;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          tx_pause = 1'b0;
  int          rx_hold_req = 0;
  int          rx_hold_taken = 0;
  int          rx_hold_left = 0;
  int          mismatch_count = 0;

  lcg_xor_stream_cipher dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // a register at zero stands for its default
  function automatic logic [lxc_pkg::WORD_W-1:0] live_reg(
      input lxc_pkg::cfg_reg_t idx,
      input logic [lxc_pkg::WORD_W-1:0] dflt);
    return (cfg_shadow[idx] == '0) ? dflt : cfg_shadow[idx];
  endfunction

  function automatic logic [7:0] cipher_byte(input logic [7:0] data_byte,
                                             input logic first);
    logic [63:0] modv;
    logic [63:0] mulv;
    logic [63:0] incv;
    logic [63:0] nxt;
    modv = {32'd0, live_reg(lxc_pkg::REG_MODULUS, lxc_pkg::DEF_MODULUS)};
    mulv = {32'd0, live_reg(lxc_pkg::REG_MULTIPLIER, lxc_pkg::DEF_MULTIPLIER)};
    incv = {32'd0, live_reg(lxc_pkg::REG_INCREMENT, lxc_pkg::DEF_INCREMENT)};
    if (first) ks_word = live_reg(lxc_pkg::REG_SEED, lxc_pkg::DEF_SEED);
    nxt = mulv * ({32'd0, ks_word} % modv) + incv;
    ks_word = nxt[31:0];
    return data_byte ^ ks_word[27:20];
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        out_expect_q.push_back(cipher_byte(s_axis_tdata, s_axis_tuser));
      end
      if (tx_words.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
        tx_next = tx_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tx_next.data_byte;
        s_axis_tuser  <= tx_next.first;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (out_expect_q.size() == 0) begin
          $error("out_byte: no word expected, got %02h", m_axis_tdata);
          mismatch_count++;
        end else begin
          out_want = out_expect_q.pop_front();
          if (m_axis_tdata !== out_want) begin
            $error("out_byte: expected %02h, got %02h", out_want, m_axis_tdata);
            mismatch_count++;
          end
        end
      end
      if (rx_hold_req != rx_hold_taken) begin
        rx_hold_taken = rx_hold_req;
        rx_hold_left  = 400;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_word(input logic [7:0] data_byte, input logic first);
    tx_words.push_back('{data_byte: data_byte, first: first});
  endtask

  task automatic wait_idle();
    while (tx_words.size() != 0 || s_axis_tvalid || out_expect_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input lxc_pkg::cfg_reg_t idx,
                           input logic [lxc_pkg::WORD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_shadow[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_all(input logic [lxc_pkg::WORD_W-1:0] value);
    for (int i = 0; i < 4; i++) cfg_write(lxc_pkg::cfg_reg_t'(i), value);
  endtask

  task automatic randomize_config();
    logic [lxc_pkg::WORD_W-1:0] v;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(7))
        0: v = '0;
        1: v = '1;
        2: v = (i == lxc_pkg::REG_MODULUS) ? $urandom_range(16, 1) : $urandom_range(255, 1);
        3: v = 32'd1 << $urandom_range(31);
        default: v = $urandom;
      endcase
      cfg_write(lxc_pkg::cfg_reg_t'(i), v);
    end
  endtask

  // messages of random length; a few flags flipped as noise
  task automatic queue_messages(input int count);
    int   msg_left;
    logic f;
    msg_left = 0;
    repeat (count) begin
      f = (msg_left == 0);
      if (f) msg_left = $urandom_range(40, 1);
      msg_left--;
      if ($urandom_range(19) == 0) f = ~f;
      push_word(8'($urandom_range(255)), f);
    end
  endtask

  initial begin
    cfg_shadow[lxc_pkg::REG_SEED]       = lxc_pkg::DEF_SEED;
    cfg_shadow[lxc_pkg::REG_MODULUS]    = lxc_pkg::DEF_MODULUS;
    cfg_shadow[lxc_pkg::REG_MULTIPLIER] = lxc_pkg::DEF_MULTIPLIER;
    cfg_shadow[lxc_pkg::REG_INCREMENT]  = lxc_pkg::DEF_INCREMENT;
    ks_word = lxc_pkg::DEF_SEED;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    tx_idle_pct = 26;
    rx_idle_pct = 66;

    // defaults, stream runs from the reset word before any first flag
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b0);
    push_word(8'ha5, 1'b0);
    push_word(8'h5a, 1'b0);
    push_word(8'h00, 1'b1);
    push_word(8'hff, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h01, 1'b0);
    wait_idle();

    // new seed mid-message only counts from the next first flag
    cfg_write(lxc_pkg::REG_SEED, 32'h1234_5678);
    push_word(8'h3c, 1'b0);
    push_word(8'hc3, 1'b0);
    push_word(8'h00, 1'b1);
    push_word(8'hff, 1'b0);
    wait_idle();

    cfg_all('1);
    push_word(8'h00, 1'b1);
    push_word(8'hff, 1'b0);
    push_word(8'h55, 1'b0);
    push_word(8'haa, 1'b0);
    wait_idle();

    // modulus of one pins the word to the increment
    cfg_write(lxc_pkg::REG_MODULUS, 32'd1);
    cfg_write(lxc_pkg::REG_MULTIPLIER, $urandom);
    cfg_write(lxc_pkg::REG_INCREMENT, $urandom);
    push_word(8'h00, 1'b1);
    push_word(8'hff, 1'b0);
    push_word(8'h12, 1'b0);
    wait_idle();

    // zero in every register falls back to the defaults
    cfg_all('0);
    push_word(8'hff, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'h7e, 1'b0);
    push_word(8'h81, 1'b0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        tx_idle_pct = 26;
        rx_idle_pct = 66;
      end else if (p < 4) begin
        tx_idle_pct = 66;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      randomize_config();
      queue_messages(140);
      if (p == 1) begin
        // long output stall while input keeps coming
        while (tx_words.size() > 100) @(negedge clk);
        rx_hold_req++;
      end
      if (p == 3) begin
        while (tx_words.size() > 70) @(negedge clk);
        tx_pause = 1'b1;
        while (out_expect_q.size() != 0 || s_axis_tvalid) @(negedge clk);
        tx_pause = 1'b0;
      end
      wait_idle();
    end

    if (mismatch_count == 0 && out_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lxc_pkg.sv
hw/rtl/lxc_seq.sv
hw/rtl/lxc_dp.sv
hw/rtl/lcg_xor_stream_cipher.sv
tb/sv/testbench.sv
